>>> design/websocket_frame_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// WebSocket frame decoder assertion macros
// Shared concurrent assertion forms used by the decoder's checks.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DECODER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Shared widths, codes and the result record of the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned LenW  = 63;
    localparam int unsigned KindW = 3;
    localparam int unsigned CodeW = 16;

    // Frame kinds reported on the result channel.
    localparam logic [KindW-1:0] KIND_CONT  = 3'd0;
    localparam logic [KindW-1:0] KIND_TEXT  = 3'd1;
    localparam logic [KindW-1:0] KIND_BIN   = 3'd2;
    localparam logic [KindW-1:0] KIND_CLOSE = 3'd3;
    localparam logic [KindW-1:0] KIND_PING  = 3'd4;
    localparam logic [KindW-1:0] KIND_PONG  = 3'd5;
    localparam logic [KindW-1:0] KIND_OTHER = 3'd6;

    // Result kinds.
    localparam logic RES_HEADER  = 1'b0;
    localparam logic RES_PAYLOAD = 1'b1;

    // Opcodes of the first header byte.
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Seven-bit length codes: the largest short length and the code that announces a 16-bit extended length.
    localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;

    typedef struct packed {
        logic             result_kind;
        logic             final_flag;
        logic [KindW-1:0] frame_kind;
        logic             masked_flag;
        logic [LenW-1:0]  payload_length;
        logic [ByteW-1:0] payload_byte;
        logic [CodeW-1:0] close_code;
        logic             close_code_valid;
        logic             last_of_frame;
    } t_result;

    function automatic logic [KindW-1:0] map_opcode(input logic [3:0] op);
        logic [KindW-1:0] k;
        case (op)
            OP_CONT:  k = KIND_CONT;
            OP_TEXT:  k = KIND_TEXT;
            OP_BIN:   k = KIND_BIN;
            OP_CLOSE: k = KIND_CLOSE;
            OP_PING:  k = KIND_PING;
            OP_PONG:  k = KIND_PONG;
            default:  k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> design/wsfd_if.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder channels
// Valid/ready channels for raw stream bytes and for decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsfd_in_if import wsfd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsfd_out_if import wsfd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             result_kind;
    logic             final_flag;
    logic [KindW-1:0] frame_kind;
    logic             masked_flag;
    logic [LenW-1:0]  payload_length;
    logic [ByteW-1:0] payload_byte;
    logic [CodeW-1:0] close_code;
    logic             close_code_valid;
    logic             last_of_frame;

    modport source (output valid, output result_kind, output final_flag,
                    output frame_kind, output masked_flag, output payload_length,
                    output payload_byte, output close_code, output close_code_valid,
                    output last_of_frame, input ready);
    modport sink   (input valid, input result_kind, input final_flag,
                    input frame_kind, input masked_flag, input payload_length,
                    input payload_byte, input close_code, input close_code_valid,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> design/websocket_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder unit
// Parses an RFC 6455 frame stream byte by byte and unmasks the payload.
// ----------------------------------------------------------------------------
// The decoder takes one raw stream byte per word on i_in and returns, on
// o_out, one header word per frame once its header is complete (opcode,
// FIN, mask bit and payload length) followed by one word per payload byte,
// already XOR-unmasked with the frame's key. The last word of each frame has
// last_of_frame set; for a close frame with at least two payload bytes that
// word also carries the big-endian close code. Header bytes before the last
// one produce no word. Throughput is one stream byte per clock when the input
// does not stall: a byte sits in the input register while the parser state
// and the unmasking logic work on it, and its word is then registered in the
// result register. The result register lets a new byte enter while a finished
// word still waits for o_out.ready; the input only stalls when the result
// register is full, not being taken, and the held byte would produce another
// word. The top bit of a 64-bit extended length is dropped, and the parser
// never resynchronizes: the byte after a frame's last payload byte always
// opens the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_decoder_unit_macros.svh"

module websocket_frame_decoder_unit
    import wsfd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    wsfd_in_if.sink     i_in,
    wsfd_out_if.source  o_out
);

    // Parse phases of the header and payload.
    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXT16,
        PH_EXT64,
        PH_KEY,
        PH_PAYLOAD
    } t_phase;

    // Input register.
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;

    // Parser state.
    t_phase           r_phase;
    logic [2:0]       r_cnt;
    logic             r_final;
    logic [KindW-1:0] r_kind;
    logic             r_masked;
    logic [LenW-1:0]  r_len;
    logic [31:0]      r_key;
    logic [LenW-1:0]  r_rem;
    logic [1:0]       r_kpos;
    logic [1:0]       r_idx;      // payload index, saturating at two
    logic [CodeW-1:0] r_hold;

    // Result register.
    logic             r_out_valid;
    t_result          r_res;

    // Next-state values.
    t_phase           n_phase;
    logic [2:0]       n_cnt;
    logic             n_final;
    logic [KindW-1:0] n_kind;
    logic             n_masked;
    logic [LenW-1:0]  n_len;
    logic [31:0]      n_key;
    logic [LenW-1:0]  n_rem;
    logic [1:0]       n_kpos;
    logic [1:0]       n_idx;
    logic [CodeW-1:0] n_hold;
    t_result          n_res;

    logic             w_emit;
    logic             w_len_done;
    logic             w_hdr;
    logic             w_last;
    logic [ByteW-1:0] w_kb;
    logic [ByteW-1:0] w_v;
    logic             w_advance;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_final    = r_final;
        n_kind     = r_kind;
        n_masked   = r_masked;
        n_len      = r_len;
        n_key      = r_key;
        n_rem      = r_rem;
        n_kpos     = r_kpos;
        n_idx      = r_idx;
        n_hold     = r_hold;
        w_emit     = 1'b0;
        w_len_done = 1'b0;
        w_hdr      = 1'b0;
        w_last     = 1'b0;
        n_res      = '0;

        // Key byte for the current payload position; zero when unmasked.
        case (r_kpos)
            2'd0:    w_kb = r_key[31:24];
            2'd1:    w_kb = r_key[23:16];
            2'd2:    w_kb = r_key[15:8];
            default: w_kb = r_key[7:0];
        endcase
        if (!r_masked) begin
            w_kb = '0;
        end
        w_v = r_in_byte ^ w_kb;

        unique case (r_phase)
            PH_FIRST: begin
                n_final = r_in_byte[7];
                n_kind  = map_opcode(r_in_byte[3:0]);
                n_phase = PH_SECOND;
            end
            PH_SECOND: begin
                n_masked = r_in_byte[7];
                n_cnt    = '0;
                if (r_in_byte[6:0] <= LEN_MAX_SHORT) begin
                    n_len      = LenW'(r_in_byte[6:0]);
                    w_len_done = 1'b1;
                end else begin
                    n_len   = '0;
                    n_phase = (r_in_byte[6:0] == LEN_EXT16) ? PH_EXT16 : PH_EXT64;
                end
            end
            PH_EXT16, PH_EXT64: begin
                // Shifting within 63 bits drops the top bit of a 64-bit length.
                n_len = {r_len[LenW-1-ByteW:0], r_in_byte};
                if ((r_phase == PH_EXT16 && r_cnt >= 3'd1) || r_cnt >= 3'd7) begin
                    w_len_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], r_in_byte};
                if (r_cnt >= 3'd3) begin
                    n_cnt = '0;
                    w_hdr = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                w_last = (r_rem == LenW'(1));
                n_rem  = r_rem - LenW'(1);
                n_kpos = r_kpos + 2'd1;
                n_idx  = (r_idx == 2'd2) ? 2'd2 : r_idx + 2'd1;
                if (r_idx == 2'd0) begin
                    n_hold = {w_v, 8'h00};
                end else if (r_idx == 2'd1) begin
                    n_hold = {r_hold[15:8], w_v};
                end
                if (w_last) begin
                    n_phase = PH_FIRST;
                end
                w_emit                 = 1'b1;
                n_res.result_kind      = RES_PAYLOAD;
                n_res.final_flag       = r_final;
                n_res.frame_kind       = r_kind;
                n_res.masked_flag      = r_masked;
                n_res.payload_length   = r_len;
                n_res.payload_byte     = w_v;
                n_res.last_of_frame    = w_last;
                // The close code is complete once the second byte is seen,
                // so a frame of length two or more can report it on its last byte.
                if (w_last && r_kind == KIND_CLOSE && r_idx != 2'd0) begin
                    n_res.close_code_valid = 1'b1;
                    n_res.close_code       = n_hold;
                end
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase

        if (w_len_done) begin
            n_rem  = n_len;
            n_kpos = '0;
            n_idx  = '0;
            n_hold = '0;
            n_cnt  = '0;
            if (n_masked) begin
                n_key   = '0;
                n_phase = PH_KEY;
            end else begin
                w_hdr = 1'b1;
            end
        end

        if (w_hdr) begin
            n_phase              = (n_len == '0) ? PH_FIRST : PH_PAYLOAD;
            w_emit               = 1'b1;
            n_res.result_kind    = RES_HEADER;
            n_res.final_flag     = n_final;
            n_res.frame_kind     = n_kind;
            n_res.masked_flag    = n_masked;
            n_res.payload_length = n_len;
            n_res.last_of_frame  = (n_len == '0);
        end
    end

    // The held byte moves on unless its word would overwrite a waiting one.
    assign w_advance  = r_in_valid && (!w_emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_FIRST;
            r_cnt       <= '0;
            r_final     <= 1'b0;
            r_kind      <= KIND_CONT;
            r_masked    <= 1'b0;
            r_len       <= '0;
            r_key       <= '0;
            r_rem       <= '0;
            r_kpos      <= '0;
            r_idx       <= '0;
            r_hold      <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_in.stream_byte;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_phase  <= n_phase;
                r_cnt    <= n_cnt;
                r_final  <= n_final;
                r_kind   <= n_kind;
                r_masked <= n_masked;
                r_len    <= n_len;
                r_key    <= n_key;
                r_rem    <= n_rem;
                r_kpos   <= n_kpos;
                r_idx    <= n_idx;
                r_hold   <= n_hold;
            end

            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
                r_res       <= n_res;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.result_kind      = r_res.result_kind;
    assign o_out.final_flag       = r_res.final_flag;
    assign o_out.frame_kind       = r_res.frame_kind;
    assign o_out.masked_flag      = r_res.masked_flag;
    assign o_out.payload_length   = r_res.payload_length;
    assign o_out.payload_byte     = r_res.payload_byte;
    assign o_out.close_code       = r_res.close_code;
    assign o_out.close_code_valid = r_res.close_code_valid;
    assign o_out.last_of_frame    = r_res.last_of_frame;

    // A close code is only reported on the final payload word of a close frame.
    `WSFD_ASSERT_SAME(a_close_code_last, i_clk, i_rst_n,
        r_out_valid && r_res.close_code_valid,
        r_res.last_of_frame && r_res.result_kind == RES_PAYLOAD
            && r_res.frame_kind == KIND_CLOSE,
        "close code reported outside the last word of a close frame")

    // While payload is being passed, at least one byte is still owed.
    `WSFD_ASSERT_SAME(a_payload_rem, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD, r_rem != '0,
        "payload phase with no bytes remaining")

    // A header that ends its frame announces an empty payload.
    `WSFD_ASSERT_SAME(a_empty_header, i_clk, i_rst_n,
        r_out_valid && r_res.result_kind == RES_HEADER && r_res.last_of_frame,
        r_res.payload_length == '0,
        "frame closed at its header with a nonzero length")

    // A waiting word that is not taken is still there in the next cycle.
    `WSFD_ASSERT_NEXT(a_out_held, i_clk, i_rst_n,
        r_out_valid && !o_out.ready, r_out_valid && $stable(r_res),
        "waiting result word was lost or changed")

endmodule

`default_nettype wire

>>> test/websocket_frame_decoder_unit_checker.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder result checker
// Watches both channels of the decoder. It keeps its own copy of the parser
// state, queues the word, if any, that each accepted stream byte should produce,
// and compares every accepted result word with the oldest queued word.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_decoder_unit_checker
    import wsfd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    wsfd_in_if   i_bytes,
    wsfd_out_if  i_words,
    output int   o_fail_count,
    output int   o_words_due,
    output int   o_headers,
    output int   o_payload_words,
    output int   o_close_codes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxPrinted = 100;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXT16,
        PH_EXT64,
        PH_KEY,
        PH_PAYLOAD
    } t_phase;

    t_phase           phase;
    logic [2:0]       field_count;
    logic             hold_fin;
    logic [KindW-1:0] hold_kind;
    logic             hold_masked;
    logic [63:0]      frame_len;
    logic [31:0]      mask_key;
    logic [63:0]      bytes_left;
    logic [1:0]       key_index;
    logic [CodeW-1:0] status_code;
    t_result          words_due[$];

    // The counters are ints and start at zero.

    task automatic report_error(input string msg);
        if (o_fail_count < MaxPrinted) begin
            $display("[%0t] decoder check: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    function automatic logic [KindW-1:0] kind_of(input logic [3:0] op);
        logic [KindW-1:0] k;
        case (op)
            OP_CONT:  k = KIND_CONT;
            OP_TEXT:  k = KIND_TEXT;
            OP_BIN:   k = KIND_BIN;
            OP_CLOSE: k = KIND_CLOSE;
            OP_PING:  k = KIND_PING;
            OP_PONG:  k = KIND_PONG;
            default:  k = KIND_OTHER;
        endcase
        return k;
    endfunction

    task automatic queue_word(input logic kind_bit, input logic [ByteW-1:0] data,
                              input logic [CodeW-1:0] code, input logic code_ok,
                              input logic last);
        t_result w;
        w.result_kind      = kind_bit;
        w.final_flag       = hold_fin;
        w.frame_kind       = hold_kind;
        w.masked_flag      = hold_masked;
        w.payload_length   = frame_len[LenW-1:0];
        w.payload_byte     = data;
        w.close_code       = code;
        w.close_code_valid = code_ok;
        w.last_of_frame    = last;
        words_due.push_back(w);
    endtask

    // The header word goes out once the last header byte is in.
    task automatic announce_frame();
        logic empty;
        empty = (frame_len == 64'd0);
        phase = empty ? PH_FIRST : PH_PAYLOAD;
        queue_word(RES_HEADER, '0, '0, 1'b0, empty);
    endtask

    task automatic close_length();
        bytes_left  = frame_len;
        key_index   = '0;
        status_code = '0;
        field_count = '0;
        if (hold_masked) begin
            mask_key = '0;
            phase    = PH_KEY;
        end else begin
            announce_frame();
        end
    endtask

    task automatic decode_byte(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] key_byte;
        logic [ByteW-1:0] plain;
        logic [63:0]      offset;
        logic             last;
        logic             code_ok;
        case (phase)
            PH_SECOND: begin
                hold_masked = b[7];
                frame_len   = '0;
                field_count = '0;
                if (b[6:0] <= LEN_MAX_SHORT) begin
                    frame_len = 64'(b[6:0]);
                    close_length();
                end else begin
                    phase = (b[6:0] == LEN_EXT16) ? PH_EXT16 : PH_EXT64;
                end
            end
            PH_EXT16: begin
                frame_len = {frame_len[55:0], b};
                if (field_count >= 3'd1) close_length();
                else field_count++;
            end
            PH_EXT64: begin
                frame_len = {frame_len[55:0], b};
                if (field_count >= 3'd7) begin
                    // The top bit of the 64-bit length is dropped.
                    frame_len[63] = 1'b0;
                    close_length();
                end else begin
                    field_count++;
                end
            end
            PH_KEY: begin
                mask_key = {mask_key[23:0], b};
                if (field_count >= 3'd3) begin
                    field_count = '0;
                    announce_frame();
                end else begin
                    field_count++;
                end
            end
            PH_PAYLOAD: begin
                key_byte = hold_masked ? mask_key[8*(3-key_index) +: 8] : 8'h00;
                plain    = b ^ key_byte;
                offset   = frame_len - bytes_left;
                if (offset == 64'd0) status_code = {plain, 8'h00};
                else if (offset == 64'd1) status_code = status_code | {8'h00, plain};
                if (bytes_left != 64'd0) bytes_left--;
                key_index++;
                last    = (bytes_left == 64'd0);
                code_ok = last && hold_kind == KIND_CLOSE && frame_len >= 64'd2;
                if (last) phase = PH_FIRST;
                queue_word(RES_PAYLOAD, plain, code_ok ? status_code : '0, code_ok, last);
            end
            default: begin
                hold_fin  = b[7];
                hold_kind = kind_of(b[3:0]);
                phase     = PH_SECOND;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic compare_word();
        t_result want;
        if (words_due.size() == 0) begin
            report_error($sformatf("word with no expectation (kind %0d, byte %02h)",
                                   i_words.result_kind, i_words.payload_byte));
            return;
        end
        want = words_due.pop_front();
        check_field("result_kind", i_words.result_kind, want.result_kind);
        check_field("final_flag", i_words.final_flag, want.final_flag);
        check_field("frame_kind", i_words.frame_kind, want.frame_kind);
        check_field("masked_flag", i_words.masked_flag, want.masked_flag);
        check_field("payload_length", i_words.payload_length, want.payload_length);
        check_field("payload_byte", i_words.payload_byte, want.payload_byte);
        check_field("close_code", i_words.close_code, want.close_code);
        check_field("close_code_valid", i_words.close_code_valid, want.close_code_valid);
        check_field("last_of_frame", i_words.last_of_frame, want.last_of_frame);
        if (i_words.result_kind == RES_HEADER) o_headers++;
        else o_payload_words++;
        if (i_words.close_code_valid === 1'b1) o_close_codes++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase       = PH_FIRST;
            field_count = '0;
            hold_fin    = 1'b0;
            hold_kind   = '0;
            hold_masked = 1'b0;
            frame_len   = '0;
            mask_key    = '0;
            bytes_left  = '0;
            key_index   = '0;
            status_code = '0;
            words_due.delete();
        end else begin
            if (i_words.valid && i_words.ready) compare_word();
            if (i_bytes.valid && i_bytes.ready) decode_byte(i_bytes.stream_byte);
        end
        o_words_due = words_due.size();
    end

endmodule

`default_nettype wire

>>> test/websocket_frame_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder unit testbench
// Feeds the decoder a stream of well-formed frames, a short directed set
// first and then random frames under three idling patterns, while a checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsfd_pkg::*;

    localparam int ClkPeriod   = 10;
    localparam int ResetCycles = 4;
    // Cycles without a single word moving on either channel before the run
    // is declared hung. Idle runs at 66 percent die out long before this.
    localparam int QuietLimit  = 5000;
    // Cycles waited after the last expected word so that anything extra is caught.
    localparam int DrainCycles = 10;
    // Stream words per idling pattern in the random part.
    localparam int PhaseBytes  = 340;
    // Seven-bit length code that announces a 64-bit extended length.
    localparam logic [6:0] LenExt64 = 7'd127;

    // How the payload length is carried in the header.
    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_16,
        FORM_64
    } t_form;

    logic clk;
    logic rst_n;

    int send_idle_pct = 16;
    int recv_idle_pct = 66;
    int bytes_sent    = 0;
    int frames_sent   = 0;
    int quiet_cycles  = 0;

    int fail_count;
    int words_due;
    int headers;
    int payload_words;
    int close_codes;

    wsfd_in_if  in_ch();
    wsfd_out_if out_ch();

    websocket_frame_decoder_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    websocket_frame_decoder_unit_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_bytes         (in_ch),
        .i_words         (out_ch),
        .o_fail_count    (fail_count),
        .o_words_due     (words_due),
        .o_headers       (headers),
        .o_payload_words (payload_words),
        .o_close_codes   (close_codes)
    );

    initial begin
        clk = 1'b0;
        forever #(ClkPeriod / 2) clk = ~clk;
    end

    // The receiver drops ready at random, at the rate of the current idling
    // pattern. Ready is decided fresh at every edge, so stalls land on header
    // words, payload words and the last word of a frame alike.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hang detection: count cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("Timeout: no word moved for %0d cycles.", QuietLimit);
            $display("** websocket_frame_decoder_unit: FAILED **");
            $finish;
        end
    end

    // Offer one stream byte and hold it until the decoder takes it. Before
    // the byte goes out the sender may idle at random, and while it idles the
    // data lines carry junk that must be ignored. Valid is left high after the
    // handshake so that back-to-back bytes need no toggle.
    task automatic send_byte(input logic [ByteW-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid       <= 1'b0;
            in_ch.stream_byte <= 8'($urandom_range(255));
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Send one frame: the opening byte, the length in the chosen form, the
    // mask key when the frame is masked, and n_body random payload bytes.
    // For a 64-bit length the top bit of len goes out as given, so setting it
    // checks that the decoder ignores it.
    task automatic send_frame(input logic [ByteW-1:0] first, input logic masked,
                              input t_form form, input logic [63:0] len,
                              input int n_body);
        send_byte(first);
        case (form)
            FORM_SHORT: begin
                send_byte({masked, len[6:0]});
            end
            FORM_16: begin
                send_byte({masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({masked, LenExt64});
                for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
        endcase
        if (masked) repeat (4) send_byte(8'($urandom_range(255)));
        repeat (n_body) send_byte(8'($urandom_range(255)));
        frames_sent++;
    endtask

    // A random well-formed frame. Opcodes favor the named kinds but any
    // nibble can show up, and FIN and the reserved bits are random. Most
    // payloads are short; a few use any short length up to 125 or a 16-bit
    // length above 125, and the 64-bit form keeps its length small.
    task automatic send_random_frame();
        logic [3:0]       op;
        logic [ByteW-1:0] first;
        logic             masked;
        t_form            form;
        logic [63:0]      len;
        int               pick;
        case ($urandom_range(6))
            0:       op = OP_CONT;
            1:       op = OP_TEXT;
            2:       op = OP_BIN;
            3:       op = OP_CLOSE;
            4:       op = OP_PING;
            5:       op = OP_PONG;
            default: op = 4'($urandom_range(15));
        endcase
        first  = {1'($urandom_range(1)), 3'($urandom_range(7)), op};
        masked = 1'($urandom_range(1));
        len    = '0;
        pick   = $urandom_range(99);
        if (pick < 65) begin
            form     = FORM_SHORT;
            len[6:0] = (pick < 6) ? 7'($urandom_range(125)) : 7'($urandom_range(12));
        end else if (pick < 85) begin
            form      = FORM_16;
            len[15:0] = (pick < 68) ? 16'($urandom_range(600, 126))
                                    : 16'($urandom_range(20));
        end else begin
            form     = FORM_64;
            len[7:0] = 8'($urandom_range(24));
            len[63]  = 1'($urandom_range(1));
        end
        send_frame(first, masked, form, len, int'(len[62:0]));
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.stream_byte <= '0;
        rst_n             <= 1'b0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames, sent with the sender idling lightly and the
        // receiver heavily. Each named opcode kind appears at least once.
        // Continuation frame with an empty payload: the header ends the frame.
        send_frame({4'h0, OP_CONT}, 1'b0, FORM_SHORT, 64'd0, 0);
        // Final text frame of one byte, unmasked, so the byte passes as is.
        send_frame({4'h8, OP_TEXT}, 1'b0, FORM_SHORT, 64'd1, 1);
        // Masked close frame of two bytes, which yields a close code.
        send_frame({4'h8, OP_CLOSE}, 1'b1, FORM_SHORT, 64'd2, 2);
        // Close frame of one byte: too short for a close code.
        send_frame({4'h0, OP_CLOSE}, 1'b0, FORM_SHORT, 64'd1, 1);
        // Ping with a 16-bit length that would fit the short form.
        send_frame({4'h8, OP_PING}, 1'b0, FORM_16, 64'd0, 0);
        // Pong with reserved bits set and a 64-bit length whose top bit is
        // set; the length must still decode as zero.
        send_frame({4'h7, OP_PONG}, 1'b0, FORM_64, 64'h8000_0000_0000_0000, 0);
        // Binary frame with all reserved bits set, and an unnamed opcode.
        send_frame({4'hF, OP_BIN}, 1'b0, FORM_SHORT, 64'd0, 0);
        send_frame(8'h8F, 1'b0, FORM_SHORT, 64'd0, 0);

        // Random frames under three idling patterns: a slow receiver, then
        // a slow sender, then both sides at full rate.
        for (int pattern = 0; pattern < 3; pattern++) begin
            int stop_at;
            stop_at = bytes_sent + PhaseBytes;
            case (pattern)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (bytes_sent < stop_at) send_random_frame();
        end

        // The largest length the result can carry: all 64 length bits set,
        // the top one dropped. Only six payload bytes follow; the decoder
        // is left in the middle of this frame when the run ends.
        send_frame({4'h8, OP_BIN}, 1'b1, FORM_64, 64'hFFFF_FFFF_FFFF_FFFF, 6);
        in_ch.valid <= 1'b0;

        // Wait at the falling edge so the checker's count is settled.
        do @(negedge clk); while (words_due != 0);
        repeat (DrainCycles) @(posedge clk);

        $display("Run covered %0d stream words in %0d frames: %0d headers, %0d payload words,",
                 bytes_sent, frames_sent, headers, payload_words);
        $display("%0d close codes, under slow-receiver, slow-sender and full-rate idling.",
                 close_codes);
        if (fail_count == 0) begin
            $display("** websocket_frame_decoder_unit: PASSED **");
        end else begin
            $display("** websocket_frame_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
